[rtl/core/u8ws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package u8ws_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned ScalarWidth  = 21;
   localparam int unsigned CountWidth   = 2;
   localparam int unsigned VerdictWidth = 2;

   typedef enum logic [VerdictWidth-1:0] {
      VERDICT_VALID   = 2'd0,
      VERDICT_INVALID = 2'd1,
      VERDICT_BLANK   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [CountWidth-1:0]  bytes_still_expected;
      logic [ScalarWidth-1:0] partial_scalar;
      logic [CountWidth-1:0]  sequence_length;
      logic                   error_seen;
      logic                   visible_seen;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      bytes_still_expected: '0,
      partial_scalar:       '0,
      sequence_length:      '0,
      error_seen:           1'b0,
      visible_seen:         1'b0
   };

   // Unicode whitespace classes
   function automatic logic is_space(input logic [ScalarWidth-1:0] cp);
      logic hit;
      hit = (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h85 ||
            cp == 21'hA0 || cp == 21'h1680 ||
            (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h2028 ||
            cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F ||
            cp == 21'h3000;
      return hit;
   endfunction

   function automatic verdict_type make_verdict(input scan_state_type st);
      verdict_type v;
      if (st.error_seen || st.bytes_still_expected != '0) begin
         v = VERDICT_INVALID;
      end else if (st.visible_seen) begin
         v = VERDICT_VALID;
      end else begin
         v = VERDICT_BLANK;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/core/u8ws_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface u8ws_req_if;
   logic                             valid;
   logic                             ready;
   logic [u8ws_pkg::ByteWidth-1:0]   data_byte;
   logic                             carries_byte;
   logic                             end_of_string;

   modport source (output valid, output data_byte, output carries_byte,
                   output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input carries_byte,
                   input end_of_string, output ready);
endinterface

interface u8ws_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [u8ws_pkg::VerdictWidth-1:0]   verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

[rtl/core/u8ws_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module u8ws_step (
   input  u8ws_pkg::scan_state_type              cur_state,
   input  logic [u8ws_pkg::ByteWidth-1:0]        data_byte,
   output u8ws_pkg::scan_state_type              nxt_state
);

   logic [u8ws_pkg::ScalarWidth-1:0] shifted;
   logic [u8ws_pkg::ScalarWidth-1:0] minimum;
   logic [u8ws_pkg::ScalarWidth-1:0] ascii_cp;

   assign shifted  = {cur_state.partial_scalar[u8ws_pkg::ScalarWidth-7:0], data_byte[5:0]};
   assign ascii_cp = {{(u8ws_pkg::ScalarWidth-u8ws_pkg::ByteWidth){1'b0}}, data_byte};

   always_comb begin
      case (cur_state.sequence_length)
         2'd1:    minimum = 21'h80;
         2'd2:    minimum = 21'h800;
         default: minimum = 21'h10000;
      endcase
   end

   always_comb begin
      nxt_state = cur_state;
      if (!cur_state.error_seen) begin
         if (cur_state.bytes_still_expected == '0) begin
            // lead byte or standalone ASCII
            if (data_byte < 8'h80) begin
               if (!u8ws_pkg::is_space(ascii_cp)) begin
                  nxt_state.visible_seen = 1'b1;
               end
            end else if (data_byte inside {[8'hC2:8'hDF]}) begin
               nxt_state.sequence_length      = 2'd1;
               nxt_state.bytes_still_expected = 2'd1;
               nxt_state.partial_scalar       = {16'd0, data_byte[4:0]};
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
               nxt_state.sequence_length      = 2'd2;
               nxt_state.bytes_still_expected = 2'd2;
               nxt_state.partial_scalar       = {17'd0, data_byte[3:0]};
            end else if (data_byte inside {[8'hF0:8'hF4]}) begin
               nxt_state.sequence_length      = 2'd3;
               nxt_state.bytes_still_expected = 2'd3;
               nxt_state.partial_scalar       = {18'd0, data_byte[2:0]};
            end else begin
               nxt_state.error_seen = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            nxt_state.error_seen = 1'b1;
         end else begin
            nxt_state.partial_scalar       = shifted;
            nxt_state.bytes_still_expected = cur_state.bytes_still_expected - 2'd1;
            if (cur_state.bytes_still_expected == 2'd1) begin
               // sequence complete: check range, then close it
               if (shifted < minimum || shifted > 21'h10FFFF ||
                   (shifted >= 21'hD800 && shifted <= 21'hDFFF)) begin
                  nxt_state.error_seen = 1'b1;
               end else if (!u8ws_pkg::is_space(shifted)) begin
                  nxt_state.visible_seen = 1'b1;
               end
               nxt_state.partial_scalar  = '0;
               nxt_state.sequence_length = '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/utf8_validator_whitespace_check_top.sv]
`timescale 1ns / 1ps
// A transaction is captured in the input register; a closing transaction's
// verdict is then registered into the result register and shown on rsp.
// Throughput: one byte per cycle, but a closing transaction waits while an
// unaccepted verdict holds the result register; the decode between the input
// register and the scan state/result registers is combinational.
// Reset (synchronous, active high) clears the scan state and both valid flags.
`default_nettype none

module utf8_validator_whitespace_check_top (
   input  wire logic       clock,
   input  wire logic       reset,
   u8ws_req_if.sink        req_bus,
   u8ws_rsp_if.source      rsp_bus
);

   // input register
   logic                               in_valid_ff;
   logic [u8ws_pkg::ByteWidth-1:0]     in_byte_ff;
   logic                               in_carries_ff;
   logic                               in_last_ff;

   // scan state and result register
   u8ws_pkg::scan_state_type           state_ff;
   u8ws_pkg::scan_state_type           state_in;
   u8ws_pkg::scan_state_type           step_out;
   u8ws_pkg::scan_state_type           stepped;
   logic                               out_valid_ff;
   u8ws_pkg::verdict_type              out_verdict_ff;

   logic                               process;

   u8ws_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .nxt_state (step_out)
   );

   // hold a closing transaction until the result register can take it
   assign process = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || process;

   assign stepped  = in_carries_ff ? step_out : state_ff;
   assign state_in = in_last_ff ? u8ws_pkg::SCAN_RESET : stepped;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= u8ws_pkg::SCAN_RESET;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (process) begin
            state_ff <= state_in;
         end
         if (process && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff    <= req_bus.data_byte;
         in_carries_ff <= req_bus.carries_byte;
         in_last_ff    <= req_bus.end_of_string;
      end
      if (process && in_last_ff) begin
         out_verdict_ff <= u8ws_pkg::make_verdict(stepped);
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.verdict = out_verdict_ff;

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int ITEM_TARGET    = 700;
   localparam int TAIL_START     = 600;
   localparam int HOLD_START     = 250;
   localparam int HOLD_ITEMS     = 80;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [7:0]            data;
      bit                    carries;
      bit                    last;
      bit                    typed;
      u8ws_pkg::verdict_type verdict;
   } stim_row_type;

   logic clock;
   logic reset;

   u8ws_req_if req_bus ();
   u8ws_rsp_if rsp_bus ();

   utf8_validator_whitespace_check_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // scan state of the predictor
   logic [1:0]  cont_owed;
   logic [20:0] cp_accum;
   logic [1:0]  cp_len;
   bit          enc_error;
   bit          saw_visible;

   stim_row_type          inflight_q[$];
   u8ws_pkg::verdict_type verdict_q[$];
   stim_row_type          directed_q[$];
   logic [7:0]            str_q[$];

   int          failures     = 0;
   int          sent         = 0;
   int          stall_cycles = 0;
   bit          quiet_tail   = 1'b0;
   bit          no_gaps      = 1'b0;
   bit          hold_request = 1'b0;

   stim_row_type          accepted_row;
   u8ws_pkg::verdict_type predicted;
   u8ws_pkg::verdict_type want;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void add_byte(input logic [7:0] b);
      str_q = {str_q, b};
   endfunction

   function automatic void add_row(input stim_row_type r);
      directed_q = {directed_q, r};
   endfunction

   function automatic void add_inflight(input stim_row_type r);
      inflight_q = {inflight_q, r};
   endfunction

   function automatic void add_verdict(input u8ws_pkg::verdict_type v);
      verdict_q = {verdict_q, v};
   endfunction

   function automatic bit is_blank_cp(input logic [20:0] cp);
      return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h85 ||
             cp == 21'hA0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
             cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F ||
             cp == 21'h205F || cp == 21'h3000;
   endfunction

   function automatic void clear_scan();
      cont_owed   = '0;
      cp_accum    = '0;
      cp_len      = '0;
      enc_error   = 1'b0;
      saw_visible = 1'b0;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      logic [20:0] min_cp;
      if (cont_owed == 2'd0) begin
         if (b < 8'h80) begin
            if (!is_blank_cp({13'd0, b})) saw_visible = 1'b1;
         end else if (b >= 8'hC2 && b <= 8'hDF) begin
            cp_len    = 2'd1;
            cont_owed = 2'd1;
            cp_accum  = {16'd0, b[4:0]};
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cp_len    = 2'd2;
            cont_owed = 2'd2;
            cp_accum  = {17'd0, b[3:0]};
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cp_len    = 2'd3;
            cont_owed = 2'd3;
            cp_accum  = {18'd0, b[2:0]};
         end else begin
            enc_error = 1'b1;
         end
      end else if (b[7:6] != 2'b10) begin
         enc_error = 1'b1;
      end else begin
         cp_accum  = {cp_accum[14:0], b[5:0]};
         cont_owed = cont_owed - 2'd1;
         if (cont_owed == 2'd0) begin
            min_cp = (cp_len == 2'd1) ? 21'h80 : (cp_len == 2'd2) ? 21'h800 : 21'h10000;
            if (cp_accum < min_cp || cp_accum > 21'h10FFFF ||
                (cp_accum >= 21'hD800 && cp_accum <= 21'hDFFF)) begin
               enc_error = 1'b1;
            end else if (!is_blank_cp(cp_accum)) begin
               saw_visible = 1'b1;
            end
            cp_accum = '0;
            cp_len   = '0;
         end
      end
   endfunction

   // Returns 1 when the transaction closes a string; v then holds the verdict.
   function automatic bit scan_item(input logic [7:0] b, input bit carries, input bit last,
                                    output u8ws_pkg::verdict_type v);
      v = u8ws_pkg::VERDICT_VALID;
      if (carries && !enc_error) absorb_byte(b);
      if (!last) return 1'b0;
      if (enc_error || cont_owed != 2'd0) v = u8ws_pkg::VERDICT_INVALID;
      else if (saw_visible) v = u8ws_pkg::VERDICT_VALID;
      else v = u8ws_pkg::VERDICT_BLANK;
      clear_scan();
      return 1'b1;
   endfunction

   function automatic stim_row_type stim(input logic [7:0] b, input bit c, input bit l,
                                         input bit t, input u8ws_pkg::verdict_type v);
      stim_row_type r;
      r.data    = b;
      r.carries = c;
      r.last    = l;
      r.typed   = t;
      r.verdict = v;
      return r;
   endfunction

   function automatic logic [20:0] pick_blank();
      logic [20:0] cp;
      int          idx;
      idx = $urandom_range(0, 17);
      case (idx)
         0, 1, 2, 3, 4: cp = 21'h09 + 21'(idx);
         5:  cp = 21'h20;
         6:  cp = 21'h85;
         7:  cp = 21'hA0;
         8:  cp = 21'h1680;
         9:  cp = 21'h2000 + 21'($urandom_range(0, 10));
         10: cp = 21'h2028;
         11: cp = 21'h2029;
         12: cp = 21'h202F;
         13: cp = 21'h205F;
         14: cp = 21'h3000;
         // near misses around the whitespace set
         15: cp = 21'h200B;
         16: cp = 21'h08;
         default: cp = 21'h202E;
      endcase
      return cp;
   endfunction

   task automatic encode_cp(input logic [20:0] cp, input int nbytes);
      case (nbytes)
         1: add_byte({1'b0, cp[6:0]});
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic build_string(input bit blank_only);
      int          n_cp;
      int          kind;
      logic [20:0] blank_cp;
      str_q.delete();
      n_cp = $urandom_range(0, 6);
      for (int i = 0; i < n_cp; i++) begin
         kind = blank_only ? 3 : $urandom_range(0, 9);
         case (kind)
            0, 1, 2: encode_cp(21'($urandom_range(0, 127)), 1);
            3, 9: begin
               // encode in the shortest form so that it stays valid
               blank_cp = pick_blank();
               if (blank_cp < 21'h80) encode_cp(blank_cp, 1);
               else if (blank_cp < 21'h800) encode_cp(blank_cp, 2);
               else encode_cp(blank_cp, 3);
            end
            4:       encode_cp(21'($urandom_range(32'h80, 32'h7FF)), 2);
            5:       encode_cp(21'($urandom_range(32'h800, 32'hFFFF)), 3);
            6:       encode_cp(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
            // arbitrary payload: overlong, out of range or bad lead
            7:       encode_cp(21'($urandom), int'($urandom_range(2, 4)));
            default: add_byte(8'($urandom_range(0, 255)));
         endcase
      end
      if (str_q.size() > 0 && $urandom_range(0, 19) == 0) void'(str_q.pop_back());
   endtask

   task automatic push_item(input stim_row_type r);
      int gap;
      if (!quiet_tail && !no_gaps && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= r.data;
      req_bus.carries_byte  <= r.carries;
      req_bus.end_of_string <= r.last;
      add_inflight(r);
      if (r.carries || r.last) sent++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_string();
      bit empty_close;
      empty_close = (str_q.size() == 0) || ($urandom_range(0, 4) == 0);
      foreach (str_q[i]) begin
         if ($urandom_range(0, 15) == 0)
            push_item(stim(8'($urandom), 1'b0, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
         push_item(stim(str_q[i], 1'b1, !empty_close && (i == str_q.size() - 1),
                        1'b0, u8ws_pkg::VERDICT_VALID));
      end
      if (empty_close)
         push_item(stim(8'($urandom), 1'b0, 1'b1, 1'b0, u8ws_pkg::VERDICT_VALID));
   endtask

   // transaction monitor and verdict checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            accepted_row = inflight_q.pop_front();
            if (scan_item(req_bus.data_byte, req_bus.carries_byte, req_bus.end_of_string,
                          predicted))
               add_verdict(accepted_row.typed ? accepted_row.verdict : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, got %0d", $time,
                        rsp_bus.verdict);
               failures++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_bus.verdict !== want) begin
                  $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want,
                           rsp_bus.verdict);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // verdict receiver
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      bit hold_done;
      hold_done              = 1'b0;
      clear_scan();
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.data_byte     <= '0;
      req_bus.carries_byte  <= 1'b0;
      req_bus.end_of_string <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(stim(8'hFF, 1'b0, 1'b1, 1'b1, u8ws_pkg::VERDICT_BLANK));
      add_row(stim(8'h41, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h00, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'hFF, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      add_row(stim(8'h80, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      add_row(stim(8'hC2, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      // next line break as two bytes
      add_row(stim(8'hC2, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h85, 1'b1, 1'b1, 1'b0, u8ws_pkg::VERDICT_VALID));
      // overlong three-byte form
      add_row(stim(8'hE0, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h80, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h80, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      // surrogate
      add_row(stim(8'hED, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'hA0, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h80, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      // above the last code point
      add_row(stim(8'hF4, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h90, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h80, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h80, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      // bytes after an error, with an empty transaction in between
      add_row(stim(8'hFF, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'hAA, 1'b0, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h20, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));
      // whitespace closed by an empty transaction
      add_row(stim(8'h20, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h00, 1'b0, 1'b1, 1'b0, u8ws_pkg::VERDICT_VALID));
      // missing continuation byte
      add_row(stim(8'hC3, 1'b1, 1'b0, 1'b0, u8ws_pkg::VERDICT_VALID));
      add_row(stim(8'h41, 1'b1, 1'b1, 1'b1, u8ws_pkg::VERDICT_INVALID));

      foreach (directed_q[i]) push_item(directed_q[i]);

      sent = 0;
      while (sent < ITEM_TARGET) begin
         if (sent >= TAIL_START) quiet_tail = 1'b1;
         if (!hold_done && sent >= HOLD_START) begin
            // stall the verdict side and keep offering closing transactions
            hold_done    = 1'b1;
            no_gaps      = 1'b1;
            hold_request = 1'b1;
            repeat (HOLD_ITEMS)
               push_item(stim(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0,
                              u8ws_pkg::VERDICT_VALID));
            no_gaps = 1'b0;
         end
         build_string($urandom_range(0, 3) == 0);
         send_string();
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
